[rtl/cbm_pkg.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// cbm_pkg
// Types, codes and constants shared by the cartridge bank mapper modules.
// ---------------------------------------------------------------------------
package cbm_pkg;

  localparam int CHR_SLOTS   = 8;
  localparam int SLOT_W      = $clog2(CHR_SLOTS);
  localparam int BANK_W      = 12;
  localparam int PRG_COUNT_W = 9;
  localparam int APB_ADDR_W  = 3;
  localparam int APB_DATA_W  = 32;

  localparam logic [PRG_COUNT_W-1:0] PRG_COUNT_RESET = 9'd32;

  localparam logic [15:0] ADDR_CHR_LO   = 16'hB000;
  localparam logic [15:0] ADDR_CHR_HI   = 16'hE00C;
  localparam logic [15:0] ADDR_PRG0     = 16'h8010;
  localparam logic [15:0] ADDR_PRG1     = 16'hA010;
  localparam logic [15:0] ADDR_MIRROR   = 16'h9400;
  localparam logic [15:0] ADDR_IRQ_LO   = 16'hF000;
  localparam logic [15:0] ADDR_IRQ_HI   = 16'hF004;
  localparam logic [15:0] ADDR_IRQ_CTRL = 16'hF008;

  localparam logic [7:0] PRESCALE_PERIOD = 8'h72;
  localparam logic [7:0] IRQ_TOP         = 8'hFF;
  localparam logic [7:0] LOCK_CLEAR      = 8'hC8;
  localparam logic [7:0] LOCK_SET        = 8'h88;
  localparam logic [7:0] CHR_RAM_PAGE0   = 8'h04;
  localparam logic [7:0] CHR_RAM_PAGE1   = 8'h05;

  localparam logic [0:0] REG_PRG_BANK_COUNT = 1'b0;

  typedef enum logic [1:0] {
    CMD_WRITE     = 2'd0,
    CMD_CLOCK     = 2'd1,
    CMD_CPU_XLATE = 2'd2,
    CMD_PPU_XLATE = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_WALK,
    ST_RESP
  } state_t;

  typedef struct packed {
    cmd_t        command;
    logic [15:0] address;
    logic [7:0]  write_data;
    logic [6:0]  cycle_count;
  } req_t;

  typedef struct packed {
    logic [BANK_W-1:0] bank_number;
    logic              bank_is_ram;
    logic [1:0]        mirroring;
    logic              irq_line;
  } rsp_t;

  typedef struct packed {
    logic              load;
    logic              exec;
    logic              walk;
    logic [SLOT_W-1:0] slot;
    logic              respond;
  } ctl_t;

  typedef struct packed {
    logic walk_req;
  } sts_t;

endpackage
`default_nettype wire

[rtl/cbm_ctrl.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// cbm_ctrl
// Sequencer: accept a word, execute it, walk the character slots when the
// word rebuilds the slot map, then issue the response.
// ---------------------------------------------------------------------------
module cbm_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  output logic               busy,
  input  wire cbm_pkg::sts_t sts,
  output cbm_pkg::ctl_t      ctl
);

  cbm_pkg::state_t state, state_next;
  logic [cbm_pkg::SLOT_W-1:0] slot, slot_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= cbm_pkg::ST_IDLE;
      slot  <= '0;
    end else begin
      state <= state_next;
      slot  <= slot_next;
    end
  end

  always_comb begin
    state_next  = state;
    slot_next   = slot;
    ctl         = '0;
    ctl.slot    = slot;
    busy        = 1'b1;
    unique case (state)
      cbm_pkg::ST_IDLE: begin
        busy     = 1'b0;
        ctl.load = start;
        if (start) begin
          state_next = cbm_pkg::ST_EXEC;
        end
      end
      cbm_pkg::ST_EXEC: begin
        ctl.exec  = 1'b1;
        slot_next = '0;
        if (sts.walk_req) begin
          state_next = cbm_pkg::ST_WALK;
        end else begin
          state_next = cbm_pkg::ST_RESP;
        end
      end
      cbm_pkg::ST_WALK: begin
        ctl.walk  = 1'b1;
        slot_next = slot + 1'b1;
        if (slot == cbm_pkg::SLOT_W'(cbm_pkg::CHR_SLOTS - 1)) begin
          state_next = cbm_pkg::ST_RESP;
        end
      end
      cbm_pkg::ST_RESP: begin
        ctl.respond = 1'b1;
        state_next  = cbm_pkg::ST_IDLE;
      end
      default: begin
        state_next = cbm_pkg::ST_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

[rtl/cbm_datapath.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// cbm_datapath
// Mapper registers, slot map, IRQ counter and the response register.
// ---------------------------------------------------------------------------
module cbm_datapath (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire cbm_pkg::req_t                     request,
  input  wire logic [cbm_pkg::PRG_COUNT_W-1:0]   prg_bank_count,
  input  wire cbm_pkg::ctl_t                     ctl,
  output cbm_pkg::sts_t                          sts,
  output logic                                   done,
  output cbm_pkg::rsp_t                          result
);

  localparam int SW = cbm_pkg::SLOT_W;
  localparam int BW = cbm_pkg::BANK_W;
  localparam int NW = cbm_pkg::PRG_COUNT_W;

  cbm_pkg::req_t req;

  logic [7:0]    char_low  [cbm_pkg::CHR_SLOTS];
  logic [3:0]    char_high [cbm_pkg::CHR_SLOTS];
  logic [BW-1:0] slot_bank [cbm_pkg::CHR_SLOTS];
  logic          slot_ram  [cbm_pkg::CHR_SLOTS];
  logic [7:0]    prog_select [2];
  logic [1:0]    mirror_mode;
  logic          ram_lock;
  logic [1:0]    irq_enable_bits;
  logic [7:0]    irq_counter;
  logic [7:0]    irq_reload;
  logic [7:0]    prescaler;
  logic          irq_pending;
  logic [BW-1:0] res_bank;
  logic          res_ram;

  logic          is_write;
  logic          in_chr;
  logic [SW-1:0] chr_idx;
  logic [SW-1:0] ppu_slot;
  logic [8:0]    psum;
  logic          tick;
  logic [8:0]    pnew;
  logic [NW-1:0] fixed0;
  logic [NW-1:0] fixed1;
  logic [BW-1:0] cpu_bank;
  logic [7:0]    walk_lo;
  logic [3:0]    walk_hi;

  assign is_write = (req.command == cbm_pkg::CMD_WRITE);
  assign in_chr   = (req.address >= cbm_pkg::ADDR_CHR_LO) &&
                    (req.address <= cbm_pkg::ADDR_CHR_HI);
  assign chr_idx  = {req.address[13:12], req.address[11] | req.address[3]} + SW'(2);
  assign ppu_slot = req.address[12:10];

  assign sts.walk_req = is_write && (in_chr ||
                        req.address == cbm_pkg::ADDR_PRG0 ||
                        req.address == cbm_pkg::ADDR_PRG1 ||
                        req.address == cbm_pkg::ADDR_MIRROR);

  assign psum = {1'b0, prescaler} + {2'b00, req.cycle_count};
  assign tick = psum >= {1'b0, cbm_pkg::PRESCALE_PERIOD};
  assign pnew = tick ? psum - {1'b0, cbm_pkg::PRESCALE_PERIOD} : psum;

  assign fixed0 = (prg_bank_count >= NW'(2)) ? prg_bank_count - NW'(2) : '0;
  assign fixed1 = (prg_bank_count >= NW'(1)) ? prg_bank_count - NW'(1) : '0;

  always_comb begin
    case (req.address[15:13])
      3'd4:    cpu_bank = BW'(prog_select[0]);
      3'd5:    cpu_bank = BW'(prog_select[1]);
      3'd6:    cpu_bank = BW'(fixed0);
      3'd7:    cpu_bank = BW'(fixed1);
      default: cpu_bank = '0;
    endcase
  end

  assign walk_lo = char_low[ctl.slot];
  assign walk_hi = char_high[ctl.slot];

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      req <= request;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < cbm_pkg::CHR_SLOTS; i++) begin
        char_low[i]  <= '0;
        char_high[i] <= '0;
        slot_bank[i] <= '0;
        slot_ram[i]  <= 1'b0;
      end
      prog_select[0]  <= '0;
      prog_select[1]  <= '0;
      mirror_mode     <= '0;
      ram_lock        <= 1'b0;
      irq_enable_bits <= '0;
      irq_counter     <= '0;
      irq_reload      <= '0;
      prescaler       <= '0;
      irq_pending     <= 1'b0;
    end else if (ctl.exec) begin
      case (req.command)
        cbm_pkg::CMD_WRITE: begin
          if (in_chr) begin
            if (req.address[2]) begin
              char_low[chr_idx][7:4] <= req.write_data[3:0];
              char_high[chr_idx]     <= req.write_data[7:4];
            end else begin
              char_low[chr_idx][3:0] <= req.write_data[3:0];
            end
          end else begin
            case (req.address)
              cbm_pkg::ADDR_PRG0:   prog_select[0]   <= req.write_data;
              cbm_pkg::ADDR_PRG1:   prog_select[1]   <= req.write_data;
              cbm_pkg::ADDR_MIRROR: mirror_mode      <= req.write_data[1:0];
              cbm_pkg::ADDR_IRQ_LO: irq_reload[3:0]  <= req.write_data[3:0];
              cbm_pkg::ADDR_IRQ_HI: irq_reload[7:4]  <= req.write_data[3:0];
              cbm_pkg::ADDR_IRQ_CTRL: begin
                irq_enable_bits <= req.write_data[1:0];
                if (req.write_data[1]) begin
                  irq_counter <= irq_reload;
                  prescaler   <= '0;
                end
                irq_pending <= 1'b0;
              end
              default: ;
            endcase
          end
        end
        cbm_pkg::CMD_CLOCK: begin
          if (irq_enable_bits[1]) begin
            prescaler <= pnew[7:0];
            if (tick) begin
              if (irq_counter == cbm_pkg::IRQ_TOP) begin
                irq_counter <= irq_reload;
                irq_pending <= 1'b1;
              end else begin
                irq_counter <= irq_counter + 8'd1;
              end
            end
          end
        end
        default: ;
      endcase
    end else if (ctl.walk) begin
      if (walk_lo == cbm_pkg::LOCK_CLEAR) begin
        ram_lock <= 1'b0;
      end else if (walk_lo == cbm_pkg::LOCK_SET) begin
        ram_lock <= 1'b1;
      end else if ((walk_lo == cbm_pkg::CHR_RAM_PAGE0 ||
                    walk_lo == cbm_pkg::CHR_RAM_PAGE1) && !ram_lock) begin
        slot_bank[ctl.slot] <= BW'(walk_lo[0]);
        slot_ram[ctl.slot]  <= 1'b1;
      end else begin
        slot_bank[ctl.slot] <= {walk_hi, walk_lo};
        slot_ram[ctl.slot]  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.exec) begin
      case (req.command)
        cbm_pkg::CMD_CPU_XLATE: begin
          res_bank <= cpu_bank;
          res_ram  <= 1'b0;
        end
        cbm_pkg::CMD_PPU_XLATE: begin
          res_bank <= slot_bank[ppu_slot];
          res_ram  <= slot_ram[ppu_slot];
        end
        default: begin
          res_bank <= '0;
          res_ram  <= 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= ctl.respond;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.respond) begin
      result.bank_number <= res_bank;
      result.bank_is_ram <= res_ram;
      result.mirroring   <= mirror_mode;
      result.irq_line    <= irq_pending;
    end
  end

endmodule
`default_nettype wire

[rtl/cartridge_bank_mapper_with_irq.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// cartridge_bank_mapper_with_irq
// Cartridge bank mapper with character slot map and cycle-driven IRQ counter.
// ---------------------------------------------------------------------------
// A word is taken when start is high and busy is low; its result appears on
// result for one cycle with done high, and must be captured then. Clock
// advances, address translations and IRQ or unmapped writes strobe done after
// the execute and response states, and the block takes a new word in the same
// cycle. Character bank, program bank and mirroring writes first rebuild the
// slot map by walking the eight character slots one per cycle.
// prg_bank_count lies at byte address 0 of the register port.
// ---------------------------------------------------------------------------
module cartridge_bank_mapper_with_irq (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            start,
  output logic                                 busy,
  input  wire cbm_pkg::req_t                   request,
  output logic                                 done,
  output cbm_pkg::rsp_t                        result,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [cbm_pkg::APB_ADDR_W-1:0]  paddr,
  input  wire logic [cbm_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [cbm_pkg::APB_DATA_W-1:0]       prdata,
  output logic                                 pready
);

  logic [cbm_pkg::PRG_COUNT_W-1:0] prg_bank_count;
  logic                            reg_hit;
  cbm_pkg::ctl_t                   ctl;
  cbm_pkg::sts_t                   sts;

  assign pready  = 1'b1;
  assign reg_hit = (paddr[2:2] == cbm_pkg::REG_PRG_BANK_COUNT);

  always_ff @(posedge clk) begin
    if (rst) begin
      prg_bank_count <= cbm_pkg::PRG_COUNT_RESET;
    end else if (psel && penable && pwrite && pready && reg_hit) begin
      prg_bank_count <= pwdata[cbm_pkg::PRG_COUNT_W-1:0];
    end
  end

  assign prdata = reg_hit ? cbm_pkg::APB_DATA_W'(prg_bank_count) : '0;

  cbm_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .ctl   (ctl)
  );

  cbm_datapath u_datapath (
    .clk            (clk),
    .rst            (rst),
    .request        (request),
    .prg_bank_count (prg_bank_count),
    .ctl            (ctl),
    .sts            (sts),
    .done           (done),
    .result         (result)
  );

  a_done_single : assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("done held for more than one cycle");

  a_accept_busy : assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted word did not raise busy");

  a_done_after_busy : assert property (@(posedge clk) disable iff (rst)
    done |-> (!busy && $past(busy)))
    else $error("done without a preceding busy cycle");

  a_walk_after_exec : assert property (@(posedge clk) disable iff (rst)
    (ctl.walk && ctl.slot == '0) |-> $past(ctl.exec))
    else $error("slot walk started without an executed write");

endmodule
`default_nettype wire
